// ===== src/matrix_multiply_engine_assert.svh =====
// Assertion macros for the matrix multiply engine.
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define MME_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define MME_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define MME_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define MME_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== src/mme_pkg.sv =====
// Shared types and constants of the matrix multiply engine.
package mme_pkg;

    localparam int ROWS_W  = 4;
    localparam int INNER_W = 5;
    localparam int COLS_W  = 4;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W   = 7;
    localparam int VAL_W   = 16;
    localparam int POS_W   = 3;
    localparam int K_W     = 6;
    localparam int PROD_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

    localparam logic [1:0] REQ_WR_INPUT  = 2'd0;
    localparam logic [1:0] REQ_WR_WEIGHT = 2'd1;
    localparam logic [1:0] REQ_COMPUTE   = 2'd2;

    localparam logic [ROWS_W-1:0]  ROWS_RST  = 4'd8;
    localparam logic [INNER_W-1:0] INNER_RST = 5'd16;
    localparam logic [COLS_W-1:0]  COLS_RST  = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_WAIT,
        ST_DRAIN
    } state_t;

    // one step of the A stream passed down the cell chain
    typedef struct packed {
        logic                    valid;
        logic                    first;
        logic                    last;
        logic [K_W-1:0]          k;
        logic signed [VAL_W-1:0] a;
    } chain_t;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        addr;
        logic signed [VAL_W-1:0] data;
    } wwr_t;

endpackage

// ===== src/mme_if.sv =====
// Item channels of the matrix multiply engine.
interface mme_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            req_type;
    logic [mme_pkg::IDX_W-1:0]             element_index;
    logic signed [mme_pkg::VAL_W-1:0]      element_value;

    modport source (output valid, req_type, element_index, element_value, input ready);
    modport sink (input valid, req_type, element_index, element_value, output ready);
endinterface

interface mme_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mme_pkg::VAL_W-1:0]      result_value;
    logic [mme_pkg::POS_W-1:0]             result_row;
    logic [mme_pkg::POS_W-1:0]             result_col;
    logic                                  last_result;

    modport source (output valid, result_value, result_row, result_col, last_result,
                    input ready);
    modport sink (input valid, result_value, result_row, result_col, last_result,
                  output ready);
endinterface

// ===== src/matrix_multiply_engine.sv =====
// Matrix multiply engine: top level with A store, sequencer and column cell chain.
// Writes are accepted one item per cycle while idle.
// Compute: accept the request, then per row feed K elements, wait until the last used
// cell finishes and drain N results; output stalls hold the drain.
// rst_n is asynchronous active low; registers reset to M=8, K=16, N=8.
// Element stores are not cleared; the user must write entries before they are read; the block does not enforce it.
`include "matrix_multiply_engine_assert.svh"
module matrix_multiply_engine #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_INNER = 16,
    parameter int MAX_COLS  = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mme_in_if.sink                            in_ch,
    mme_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]         cfg_data
);
    localparam int IN_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int IN_AW    = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int W_DEPTH  = MAX_INNER * MAX_COLS;
    localparam int W_AW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int ACC_W    = mme_pkg::PROD_W + $clog2(MAX_INNER) + 1;
    localparam int COL_SW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SZ_W     = mme_pkg::INNER_W + mme_pkg::ROWS_W;

    logic [mme_pkg::ROWS_W-1:0]  rows_reg;
    logic [mme_pkg::INNER_W-1:0] inner_reg;
    logic [mme_pkg::COLS_W-1:0]  cols_reg;
    logic [mme_pkg::ROWS_W-1:0]  m_dim;
    logic [mme_pkg::INNER_W-1:0] k_dim;
    logic [mme_pkg::COLS_W-1:0]  n_dim;
    logic [SZ_W-1:0]             mk, kn;

    mme_pkg::state_t             state_reg, state_next;
    logic [mme_pkg::INNER_W-1:0] k_cnt_reg, k_cnt_next;
    logic [mme_pkg::POS_W-1:0]   m_reg, m_next, col_reg, col_next;
    logic [IN_AW-1:0]            a_addr_reg, a_addr_next;
    logic                        issue, shift, load_out, in_fire, done_last;
    logic                        fv_reg, ff_reg, fl_reg;
    logic [mme_pkg::INNER_W-1:0] fk_reg;
    logic signed [mme_pkg::VAL_W-1:0] a_rdata_reg;
    logic signed [mme_pkg::VAL_W-1:0] a_mem [IN_DEPTH];

    logic                             out_valid_reg, out_last_reg;
    logic signed [mme_pkg::VAL_W-1:0] out_value_reg;
    logic [mme_pkg::POS_W-1:0]        out_row_reg, out_col_reg;

    mme_pkg::chain_t                  chain [MAX_COLS+1];
    logic signed [mme_pkg::VAL_W-1:0] res_w [MAX_COLS+1];
    logic [MAX_COLS-1:0]              done_vec;
    mme_pkg::wwr_t                    wwr;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= mme_pkg::ROWS_RST;
            inner_reg <= mme_pkg::INNER_RST;
            cols_reg  <= mme_pkg::COLS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mme_pkg::CFG_ROWS:  rows_reg  <= cfg_data[mme_pkg::ROWS_W-1:0];
                mme_pkg::CFG_INNER: inner_reg <= cfg_data;
                mme_pkg::CFG_COLS:  cols_reg  <= cfg_data[mme_pkg::COLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (rows_reg == '0)
            m_dim = mme_pkg::ROWS_W'(1);
        else if (int'(rows_reg) > MAX_ROWS)
            m_dim = mme_pkg::ROWS_W'(MAX_ROWS);
        else
            m_dim = rows_reg;
        if (inner_reg == '0)
            k_dim = mme_pkg::INNER_W'(1);
        else if (int'(inner_reg) > MAX_INNER)
            k_dim = mme_pkg::INNER_W'(MAX_INNER);
        else
            k_dim = inner_reg;
        if (cols_reg == '0)
            n_dim = mme_pkg::COLS_W'(1);
        else if (int'(cols_reg) > MAX_COLS)
            n_dim = mme_pkg::COLS_W'(MAX_COLS);
        else
            n_dim = cols_reg;
        mk = SZ_W'(m_dim) * SZ_W'(k_dim);
        kn = SZ_W'(k_dim) * SZ_W'(n_dim);
    end

    assign in_ch.ready = (state_reg == mme_pkg::ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    // element writes
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.req_type == mme_pkg::REQ_WR_INPUT
            && SZ_W'(in_ch.element_index) < mk && int'(in_ch.element_index) < IN_DEPTH)
        begin
            a_mem[IN_AW'(in_ch.element_index)] <= in_ch.element_value;
        end
        a_rdata_reg <= a_mem[a_addr_reg];
    end

    assign wwr.we   = in_fire && in_ch.req_type == mme_pkg::REQ_WR_WEIGHT
                      && SZ_W'(in_ch.element_index) < kn
                      && int'(in_ch.element_index) < W_DEPTH;
    assign wwr.addr = in_ch.element_index;
    assign wwr.data = in_ch.element_value;

    // sequencer
    assign done_last = done_vec[COL_SW'(n_dim - mme_pkg::COLS_W'(1))];

    always_comb
    begin
        state_next  = state_reg;
        k_cnt_next  = k_cnt_reg;
        m_next      = m_reg;
        col_next    = col_reg;
        a_addr_next = a_addr_reg;
        issue       = 1'b0;
        shift       = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                if (in_fire && in_ch.req_type == mme_pkg::REQ_COMPUTE)
                begin
                    state_next  = mme_pkg::ST_FEED;
                    k_cnt_next  = '0;
                    m_next      = '0;
                    a_addr_next = '0;
                end
            end
            mme_pkg::ST_FEED:
            begin
                issue       = 1'b1;
                a_addr_next = a_addr_reg + IN_AW'(1);
                if (k_cnt_reg == k_dim - mme_pkg::INNER_W'(1))
                begin
                    k_cnt_next = '0;
                    state_next = mme_pkg::ST_WAIT;
                end
                else
                begin
                    k_cnt_next = k_cnt_reg + mme_pkg::INNER_W'(1);
                end
            end
            mme_pkg::ST_WAIT:
            begin
                if (done_last)
                begin
                    state_next = mme_pkg::ST_DRAIN;
                    col_next   = '0;
                end
            end
            mme_pkg::ST_DRAIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    load_out = 1'b1;
                    shift    = 1'b1;
                    if ({1'b0, col_reg} == n_dim - mme_pkg::COLS_W'(1))
                    begin
                        if ({1'b0, m_reg} == m_dim - mme_pkg::ROWS_W'(1))
                        begin
                            state_next = mme_pkg::ST_IDLE;
                        end
                        else
                        begin
                            m_next     = m_reg + mme_pkg::POS_W'(1);
                            state_next = mme_pkg::ST_FEED;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + mme_pkg::POS_W'(1);
                    end
                end
            end
            default: state_next = mme_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mme_pkg::ST_IDLE;
            k_cnt_reg     <= '0;
            m_reg         <= '0;
            col_reg       <= '0;
            a_addr_reg    <= '0;
            fv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_cnt_reg  <= k_cnt_next;
            m_reg      <= m_next;
            col_reg    <= col_next;
            a_addr_reg <= a_addr_next;
            fv_reg     <= issue;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ff_reg <= (k_cnt_reg == '0);
        fl_reg <= (k_cnt_reg == k_dim - mme_pkg::INNER_W'(1));
        fk_reg <= k_cnt_reg;
        if (load_out)
        begin
            out_value_reg <= res_w[0];
            out_row_reg   <= m_reg;
            out_col_reg   <= col_reg;
            out_last_reg  <= ({1'b0, col_reg} == n_dim - mme_pkg::COLS_W'(1))
                             && ({1'b0, m_reg} == m_dim - mme_pkg::ROWS_W'(1));
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_value_reg;
    assign out_ch.result_row   = out_row_reg;
    assign out_ch.result_col   = out_col_reg;
    assign out_ch.last_result  = out_last_reg;

    // cell chain
    assign chain[0].valid = fv_reg;
    assign chain[0].first = ff_reg;
    assign chain[0].last  = fl_reg;
    assign chain[0].k     = mme_pkg::K_W'(fk_reg);
    assign chain[0].a     = a_rdata_reg;
    assign res_w[MAX_COLS] = '0;

    for (genvar n = 0; n < MAX_COLS; n++)
    begin : g_cell
        mme_cell #(
            .COL     (n),
            .W_DEPTH (W_DEPTH),
            .W_AW    (W_AW),
            .ACC_W   (ACC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .n_dim     (n_dim),
            .wwr       (wwr),
            .chain_in  (chain[n]),
            .chain_out (chain[n+1]),
            .shift     (shift),
            .shift_in  (res_w[n+1]),
            .res       (res_w[n]),
            .done      (done_vec[n])
        );
    end

    `MME_ASSERT_IMP(a_done_in_wait, clk, rst_n, done_last, state_reg == mme_pkg::ST_WAIT)
    `MME_ASSERT_IMP(a_col_range, clk, rst_n, out_valid_reg, {1'b0, out_col_reg} < n_dim)
    `MME_ASSERT_IMP(a_last_pos, clk, rst_n, out_valid_reg && out_last_reg, ({1'b0, out_row_reg} == m_dim - mme_pkg::ROWS_W'(1)) && ({1'b0, out_col_reg} == n_dim - mme_pkg::COLS_W'(1)))
    `MME_ASSERT_NXT(a_feed_done, clk, rst_n, state_reg == mme_pkg::ST_FEED && k_cnt_reg == k_dim - mme_pkg::INNER_W'(1), state_reg == mme_pkg::ST_WAIT && chain[0].last)
endmodule

// ===== src/mme_cell.sv =====
// One column cell: weight copy, multiply, accumulate, result shift stage.
module mme_cell #(
    parameter int COL     = 0,
    parameter int W_DEPTH = 128,
    parameter int W_AW    = 7,
    parameter int ACC_W   = 37
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mme_pkg::COLS_W-1:0]        n_dim,
    input  mme_pkg::wwr_t                     wwr,
    input  mme_pkg::chain_t                   chain_in,
    output mme_pkg::chain_t                   chain_out,
    input  logic                              shift,
    input  logic signed [mme_pkg::VAL_W-1:0]  shift_in,
    output logic signed [mme_pkg::VAL_W-1:0]  res,
    output logic                              done
);
    localparam int ADDR_FULL_W = mme_pkg::K_W + mme_pkg::COLS_W;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(32768));

    logic signed [mme_pkg::VAL_W-1:0] wmem [W_DEPTH];

    mme_pkg::chain_t                  s0_reg;
    logic                             v1_reg, f1_reg, l1_reg;
    logic signed [mme_pkg::VAL_W-1:0] a1_reg, w1_reg;
    logic                             v2_reg, f2_reg, l2_reg;
    logic signed [mme_pkg::PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]          acc_reg, acc_next, sh;
    logic signed [mme_pkg::VAL_W-1:0] res_reg;
    logic                             done_reg;
    logic [ADDR_FULL_W-1:0]           rd_full;

    assign chain_out = s0_reg;
    assign res  = res_reg;
    assign done = done_reg;

    // column n of row k sits at k*N + n
    assign rd_full = ADDR_FULL_W'(s0_reg.k) * ADDR_FULL_W'(n_dim) + ADDR_FULL_W'(COL);

    always_ff @(posedge clk)
    begin
        if (wwr.we)
        begin
            wmem[W_AW'(wwr.addr)] <= wwr.data;
        end
        w1_reg <= wmem[W_AW'(rd_full)];
    end

    always_comb
    begin
        acc_next = f2_reg ? {{(ACC_W-mme_pkg::PROD_W){prod_reg[mme_pkg::PROD_W-1]}}, prod_reg}
                          : acc_reg + {{(ACC_W-mme_pkg::PROD_W){prod_reg[mme_pkg::PROD_W-1]}},
                                       prod_reg};
        sh = acc_next >>> 8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg   <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s0_reg   <= chain_in;
            v1_reg   <= s0_reg.valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg && l2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg   <= s0_reg.a;
        f1_reg   <= s0_reg.first;
        l1_reg   <= s0_reg.last;
        prod_reg <= a1_reg * w1_reg;
        f2_reg   <= f1_reg;
        l2_reg   <= l1_reg;
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (v2_reg && l2_reg)
        begin
            if (sh > SAT_HI)
                res_reg <= 16'sh7fff;
            else if (sh < SAT_LO)
                res_reg <= 16'sh8000;
            else
                res_reg <= sh[mme_pkg::VAL_W-1:0];
        end
        else if (shift)
        begin
            res_reg <= shift_in;
        end
    end
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the matrix multiply engine: directed and random element writes and computes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]                       req;
        logic [mme_pkg::IDX_W-1:0]        idx;
        logic signed [mme_pkg::VAL_W-1:0] val;
    } req_item_t;

    typedef struct {
        logic signed [mme_pkg::VAL_W-1:0] value;
        logic [mme_pkg::POS_W-1:0]        row;
        logic [mme_pkg::POS_W-1:0]        col;
        logic                             last;
    } product_t;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [mme_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mme_pkg::CFG_W-1:0] cfg_data;

    mme_in_if  in_bus();
    mme_out_if out_bus();

    matrix_multiply_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_bus),
        .out_ch    (out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    req_item_t pending_items[$];
    product_t  expected_products[$];

    // predictor state
    logic [mme_pkg::ROWS_W-1:0]       m_reg;
    logic [mme_pkg::INNER_W-1:0]      k_reg;
    logic [mme_pkg::COLS_W-1:0]       n_reg;
    logic signed [mme_pkg::VAL_W-1:0] a_mem [128];
    logic signed [mme_pkg::VAL_W-1:0] b_mem [128];

    // stimulus-side view of which entries hold data
    bit a_written [128];
    bit b_written [128];
    int gen_m, gen_k, gen_n;

    int  errors;
    bit  quiet;
    bit  took;
    int  in_gap;
    int  out_stall;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic signed [mme_pkg::VAL_W-1:0] q88_saturate(longint acc);
        longint q;
        q = acc >>> 8;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[mme_pkg::VAL_W-1:0];
    endfunction

    task automatic predict_item(req_item_t it);
        int m, n, k;
        int md, kd, nd;
        longint acc;
        product_t p;
        md = clamp_dim(int'(m_reg), 8);
        kd = clamp_dim(int'(k_reg), 16);
        nd = clamp_dim(int'(n_reg), 8);
        case (it.req)
            mme_pkg::REQ_WR_INPUT:  if (it.idx < md * kd) a_mem[it.idx] = it.val;
            mme_pkg::REQ_WR_WEIGHT: if (it.idx < kd * nd) b_mem[it.idx] = it.val;
            mme_pkg::REQ_COMPUTE:
            begin
                for (m = 0; m < md; m++)
                begin
                    for (n = 0; n < nd; n++)
                    begin
                        acc = 0;
                        for (k = 0; k < kd; k++)
                            acc += longint'(a_mem[m * kd + k]) * longint'(b_mem[k * nd + n]);
                        p.value = q88_saturate(acc);
                        p.row   = m[mme_pkg::POS_W-1:0];
                        p.col   = n[mme_pkg::POS_W-1:0];
                        p.last  = (m == md - 1) && (n == nd - 1);
                        expected_products.push_back(p);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_bus.valid <= 1'b0;
        end
        else if (in_bus.valid && !took)
        begin
            // hold the item until it is taken
        end
        else
        begin
            if (in_gap == 0 && !quiet && $urandom_range(0, 15) == 0)
                in_gap = $urandom_range(1, 15);
            if (in_gap > 0)
            begin
                in_gap--;
                in_bus.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_bus.valid         <= 1'b1;
                in_bus.req_type      <= pending_items[0].req;
                in_bus.element_index <= pending_items[0].idx;
                in_bus.element_value <= pending_items[0].val;
            end
            else
            begin
                in_bus.valid <= 1'b0;
            end
        end
        took = 1'b0;

        if (out_stall == 0 && !quiet && $urandom_range(0, 12) == 0)
            out_stall = $urandom_range(1, 15);
        if (out_stall > 0)
        begin
            out_stall--;
            out_bus.ready <= 1'b0;
        end
        else
        begin
            out_bus.ready <= 1'b1;
        end
    end

    // input acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && in_bus.valid && in_bus.ready)
        begin
            predict_item(pending_items.pop_front());
            took = 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        product_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (expected_products.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: value %0d row %0d col %0d last %0b",
                             out_bus.result_value, out_bus.result_row,
                             out_bus.result_col, out_bus.last_result);
            end
            else
            begin
                want = expected_products.pop_front();
                if (out_bus.result_value !== want.value || out_bus.result_row !== want.row
                    || out_bus.result_col !== want.col || out_bus.last_result !== want.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d r%0d c%0d l%0b, got %0d r%0d c%0d l%0b",
                                 want.value, want.row, want.col, want.last,
                                 out_bus.result_value, out_bus.result_row,
                                 out_bus.result_col, out_bus.last_result);
                end
            end
        end
    end

    task automatic write_reg(logic [mme_pkg::CFG_IDX_W-1:0] idx,
                             logic [mme_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            mme_pkg::CFG_ROWS:  m_reg = data[mme_pkg::ROWS_W-1:0];
            mme_pkg::CFG_INNER: k_reg = data[mme_pkg::INNER_W-1:0];
            mme_pkg::CFG_COLS:  n_reg = data[mme_pkg::COLS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_dims(int m, int k, int n);
        write_reg(mme_pkg::CFG_ROWS, mme_pkg::CFG_W'(m));
        write_reg(mme_pkg::CFG_INNER, mme_pkg::CFG_W'(k));
        write_reg(mme_pkg::CFG_COLS, mme_pkg::CFG_W'(n));
        gen_m = clamp_dim(int'(m[mme_pkg::ROWS_W-1:0]), 8);
        gen_k = clamp_dim(int'(k[mme_pkg::INNER_W-1:0]), 16);
        gen_n = clamp_dim(int'(n[mme_pkg::COLS_W-1:0]), 8);
    endtask

    function automatic logic signed [mme_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return mme_pkg::VAL_W'($urandom_range(0, 1023) - 512);
            default: return mme_pkg::VAL_W'($urandom());
        endcase
    endfunction

    task automatic push_item(logic [1:0] req, int idx, logic signed [mme_pkg::VAL_W-1:0] val);
        req_item_t it;
        it.req = req;
        it.idx = idx[mme_pkg::IDX_W-1:0];
        it.val = val;
        if (req == mme_pkg::REQ_WR_INPUT && idx < gen_m * gen_k) a_written[idx] = 1'b1;
        if (req == mme_pkg::REQ_WR_WEIGHT && idx < gen_k * gen_n) b_written[idx] = 1'b1;
        pending_items.push_back(it);
    endtask

    // every entry a compute reads must hold data first
    task automatic push_compute();
        int i;
        for (i = 0; i < gen_m * gen_k; i++)
            if (!a_written[i]) push_item(mme_pkg::REQ_WR_INPUT, i, rand_value());
        for (i = 0; i < gen_k * gen_n; i++)
            if (!b_written[i]) push_item(mme_pkg::REQ_WR_WEIGHT, i, rand_value());
        push_item(mme_pkg::REQ_COMPUTE, int'($urandom_range(0, 127)),
                  mme_pkg::VAL_W'($urandom()));
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_products.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int i, sel, asz, bsz;
        asz = gen_m * gen_k;
        bsz = gen_k * gen_n;
        for (i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
                push_item(mme_pkg::REQ_WR_INPUT, int'($urandom_range(0, asz - 1)),
                          rand_value());
            else if (sel < 70)
                push_item(mme_pkg::REQ_WR_WEIGHT, int'($urandom_range(0, bsz - 1)),
                          rand_value());
            else if (sel < 78)
                push_item(2'($urandom_range(0, 1)), int'($urandom_range(0, 127)),
                          mme_pkg::VAL_W'($urandom()));
            else if (sel < 86)
                push_item(REQ_UNUSED, int'($urandom_range(0, 127)),
                          mme_pkg::VAL_W'($urandom()));
            else
                push_compute();
        end
        push_compute();
        wait_idle();
    endtask

    initial
    begin
        int i;
        errors = 0;
        quiet = 1'b0;
        took = 1'b0;
        in_gap = 0;
        out_stall = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mme_pkg::CFG_ROWS;
        cfg_data = '0;
        in_bus.valid = 1'b0;
        in_bus.req_type = mme_pkg::REQ_WR_INPUT;
        in_bus.element_index = '0;
        in_bus.element_value = '0;
        out_bus.ready = 1'b0;
        m_reg = mme_pkg::ROWS_RST;
        k_reg = mme_pkg::INNER_RST;
        n_reg = mme_pkg::COLS_RST;
        gen_m = 8;
        gen_k = 16;
        gen_n = 8;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 2x2x2 with extremes, ignored writes, unknown request, saturation
        set_dims(2, 2, 2);
        push_item(mme_pkg::REQ_WR_INPUT, 0, 16'sh7FFF);
        push_item(mme_pkg::REQ_WR_INPUT, 1, 16'sh7FFF);
        push_item(mme_pkg::REQ_WR_INPUT, 2, 16'sh8000);
        push_item(mme_pkg::REQ_WR_INPUT, 3, 16'sh0100);
        push_item(mme_pkg::REQ_WR_WEIGHT, 0, 16'sh7FFF);
        push_item(mme_pkg::REQ_WR_WEIGHT, 1, 16'sh8000);
        push_item(mme_pkg::REQ_WR_WEIGHT, 2, 16'sh7FFF);
        push_item(mme_pkg::REQ_WR_WEIGHT, 3, 16'shFFFF);
        push_item(mme_pkg::REQ_WR_INPUT, 4, 16'sh1234);
        push_item(mme_pkg::REQ_WR_WEIGHT, 127, 16'sh5555);
        push_item(REQ_UNUSED, 127, 16'shFFFF);
        push_item(mme_pkg::REQ_COMPUTE, 127, 16'shAAAA);
        push_item(mme_pkg::REQ_WR_INPUT, 1, 16'shFFFF);
        push_item(mme_pkg::REQ_WR_WEIGHT, 2, 16'sh0001);
        push_item(mme_pkg::REQ_COMPUTE, 0, 16'sh0000);
        wait_idle();

        // registers out of range act as their bounds
        set_dims(0, 0, 0);
        push_item(mme_pkg::REQ_WR_INPUT, 1, 16'sh7777);
        push_item(mme_pkg::REQ_WR_INPUT, 0, 16'shFF80);
        push_item(mme_pkg::REQ_WR_WEIGHT, 0, 16'sh0180);
        push_compute();
        wait_idle();

        set_dims(15, 2, 1);
        random_phase(15);

        set_dims(1, 31, 1);
        random_phase(15);

        set_dims(1, 2, 15);
        random_phase(15);

        for (i = 0; i < 3; i++)
        begin
            set_dims(int'($urandom_range(0, 3)), int'($urandom_range(0, 5)),
                     int'($urandom_range(0, 3)));
            random_phase(15);
        end

        quiet = 1'b1;
        set_dims(int'($urandom_range(1, 4)), int'($urandom_range(1, 6)),
                 int'($urandom_range(1, 4)));
        random_phase(25);

        if (expected_products.size() != 0)
            errors++;
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/mme_pkg.sv
src/mme_if.sv
src/mme_cell.sv
src/matrix_multiply_engine.sv
tb/tb.sv
